### rtl/wstq_pkg.sv
// wstq_pkg: shared constants, command and status codes for the work-stealing
// task queues; used by wstq_modu and work_stealing_task_queues
// no dependencies
package wstq_pkg;

  localparam int unsigned WORKERS_DEF     = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TAG_BITS_DEF    = 16;

  localparam logic [63:0] RNG_SEED = 64'h9e37_79b9_7f4a_7c15;

  // bits of the generator value folded into the remainder per cycle
  localparam int unsigned MOD_STEP = 4;

  // command codes
  localparam logic [1:0] CMD_PUSH_LL    = 2'd0;
  localparam logic [1:0] CMD_PUSH_NAMED = 2'd1;
  localparam logic [1:0] CMD_DEQUEUE    = 2'd2;
  localparam logic [1:0] CMD_STEAL      = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_BAD_WORKER  = 3'd3;
  localparam logic [2:0] ST_THIEF_BUSY  = 3'd4;
  localparam logic [2:0] ST_NO_STEAL    = 3'd5;

  // reset value of one worker's generator
  function automatic logic [63:0] rng_seed(input int unsigned idx);
    logic [63:0] k;
    k = 64'(idx + 1);
    return 64'(RNG_SEED * k);
  endfunction

  // one xorshift64 step
  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

### rtl/work_stealing_task_queues.sv
// work_stealing_task_queues: per-worker job queues with push, dequeue and steal
// depends on wstq_pkg and wstq_modu
//
// Usage: present a command on cmd_i/worker_i/job_tag_i/stealable_i/dispatched_i
// and raise start; the command transfers at a clock edge with start high and
// busy low. busy then stays high until the result is out; a bad worker or an
// empty dequeue is answered with busy low. Each command gives exactly one
// result on status_o, job_tag_out_o, job_stealable_out_o, target_worker_o and
// moved_count_o, shown for one cycle with valid_o high; the receiver takes it
// in that cycle and cannot hold it off. Named push writes in S_PUSH; push to
// least loaded first scans every worker in S_LL; dequeue reads the front entry
// and finishes in S_DEQ. A steal runs the thief's next generator value through
// the shared iterative remainder unit to pick the victim, then makes one
// counting pass and one moving pass over the victim's queue, reading each entry.
// Queues are circular buffers in one single-port-write memory, which sets the
// per-entry pace of a steal. Reset empties all queues and reloads the
// generators; the memory holds no reset value and is only read below a count.
module work_stealing_task_queues #(
  parameter int unsigned WORKERS     = wstq_pkg::WORKERS_DEF,
  parameter int unsigned QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = wstq_pkg::TAG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  worker_i,
  input  logic [15:0] job_tag_i,
  input  logic        stealable_i,
  input  logic        dispatched_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] job_tag_out_o,
  output logic        job_stealable_out_o,
  output logic [2:0]  target_worker_o,
  output logic [4:0]  moved_count_o
);
  import wstq_pkg::*;

  localparam int unsigned W_BITS = $clog2(WORKERS);
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRIES = WORKERS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(ENTRIES);
  localparam int unsigned ENT_W  = TAG_BITS + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LL      = 4'd1;
  localparam logic [3:0] S_PUSH    = 4'd2;
  localparam logic [3:0] S_DEQ     = 4'd3;
  localparam logic [3:0] S_RNG     = 4'd4;
  localparam logic [3:0] S_CNT_RD  = 4'd5;
  localparam logic [3:0] S_CNT_CHK = 4'd6;
  localparam logic [3:0] S_MV_RD   = 4'd7;
  localparam logic [3:0] S_MV_PROC = 4'd8;

  // physical address of a logical position in one worker's ring
  function automatic logic [ADDR_W-1:0] phys(input logic [W_BITS-1:0] wk,
                                             input logic [PTR_W-1:0]  hd,
                                             input logic [CNT_W-1:0]  lg);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(hd) + (CNT_W+1)'(lg);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return ADDR_W'(ADDR_W'(wk) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(s);
  endfunction

  // queue memory
  logic [ENT_W-1:0]  mem_q [ENTRIES];
  logic [ENT_W-1:0]  rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0]  mem_wdata;

  // per-worker state
  logic [CNT_W-1:0] counts_q [WORKERS];
  logic [CNT_W-1:0] counts_d [WORKERS];
  logic [PTR_W-1:0] head_q   [WORKERS];
  logic [PTR_W-1:0] head_d   [WORKERS];
  logic [63:0]      rng_q    [WORKERS];
  logic [63:0]      rng_d    [WORKERS];

  // sequencer and working registers
  logic [3:0]        state_q, state_d;
  logic [W_BITS-1:0] wk_q, wk_d;
  logic [W_BITS-1:0] tgt_q, tgt_d;
  logic [W_BITS-1:0] best_q, best_d;
  logic [W_BITS-1:0] ll_q, ll_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic              st_q, st_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  take_q, take_d;
  logic [CNT_W-1:0]  got_q, got_d;
  logic [CNT_W-1:0]  wp_q, wp_d;

  // result register
  logic              valid_q, valid_d;
  logic [2:0]        status_q, status_d;
  logic [15:0]       tag_out_q, tag_out_d;
  logic              st_out_q, st_out_d;
  logic [2:0]        tgt_out_q, tgt_out_d;
  logic [4:0]        moved_q, moved_d;

  // shared remainder unit
  logic              mod_start, mod_done;
  logic [63:0]       mod_value;
  logic [W_BITS-1:0] mod_rem;

  wstq_modu #(
    .DIVISOR (WORKERS - 1),
    .REM_W   (W_BITS)
  ) u_modu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // tag width adaption
  logic [TAG_BITS+47:0] tag_in_ext;
  logic [TAG_BITS+15:0] tag_out_ext;
  assign tag_in_ext  = {TAG_BITS'(0), 32'd0, job_tag_i};
  assign tag_out_ext = {16'd0, rd_q[TAG_BITS-1:0]};

  // sequencer
  always_comb begin
    logic [W_BITS-1:0] wi;
    logic [W_BITS-1:0] cand;
    logic [W_BITS-1:0] vic;
    logic [CNT_W-1:0]  nn;
    logic [CNT_W-1:0]  tk;
    logic [63:0]       nxt;
    state_d   = state_q;
    wk_d      = wk_q;
    tgt_d     = tgt_q;
    best_d    = best_q;
    ll_d      = ll_q;
    tag_d     = tag_q;
    st_d      = st_q;
    idx_d     = idx_q;
    n_d       = n_q;
    take_d    = take_q;
    got_d     = got_q;
    wp_d      = wp_q;
    counts_d  = counts_q;
    head_d    = head_q;
    rng_d     = rng_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    tag_out_d = tag_out_q;
    st_out_d  = st_out_q;
    tgt_out_d = tgt_out_q;
    moved_d   = moved_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mod_start = 1'b0;
    mod_value = '0;
    wi        = worker_i[W_BITS-1:0];
    cand      = '0;
    vic       = '0;
    nn        = '0;
    tk        = '0;
    nxt       = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          tag_d     = tag_in_ext[TAG_BITS-1:0];
          st_d      = stealable_i | dispatched_i;
          wk_d      = wi;
          status_d  = ST_OK;
          tag_out_d = '0;
          st_out_d  = 1'b0;
          tgt_out_d = '0;
          moved_d   = '0;
          if (cmd_i == CMD_PUSH_LL) begin
            best_d  = '0;
            ll_d    = W_BITS'(1);
            state_d = S_LL;
          end else if (32'(worker_i) >= WORKERS) begin
            status_d = ST_BAD_WORKER;
            valid_d  = 1'b1;
          end else if (cmd_i == CMD_PUSH_NAMED) begin
            tgt_d   = wi;
            state_d = S_PUSH;
          end else if (cmd_i == CMD_DEQUEUE) begin
            if (counts_q[wi] == '0) begin
              status_d = ST_EMPTY;
              valid_d  = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = phys(wi, head_q[wi], '0);
              state_d   = S_DEQ;
            end
          end else begin
            nxt       = xorshift(rng_q[wi]);
            rng_d[wi] = nxt;
            mod_start = 1'b1;
            mod_value = nxt;
            state_d   = S_RNG;
          end
        end
      end

      // least-loaded scan, one worker per cycle
      S_LL: begin
        cand = (counts_q[ll_q] < counts_q[best_q]) ? ll_q : best_q;
        if (ll_q == W_BITS'(WORKERS - 1)) begin
          tgt_d   = cand;
          state_d = S_PUSH;
        end else begin
          best_d = cand;
          ll_d   = ll_q + W_BITS'(1);
        end
      end

      S_PUSH: begin
        tgt_out_d = 3'(tgt_q);
        valid_d   = 1'b1;
        state_d   = S_IDLE;
        if (counts_q[tgt_q] >= CNT_W'(QUEUE_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = phys(tgt_q, head_q[tgt_q], counts_q[tgt_q]);
          mem_wdata        = {st_q, tag_q};
          counts_d[tgt_q]  = counts_q[tgt_q] + CNT_W'(1);
        end
      end

      // front entry is in the read register
      S_DEQ: begin
        tag_out_d = tag_out_ext[15:0];
        st_out_d  = rd_q[TAG_BITS];
        valid_d   = 1'b1;
        state_d   = S_IDLE;
        counts_d[wk_q] = counts_q[wk_q] - CNT_W'(1);
        if (head_q[wk_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
          head_d[wk_q] = '0;
        end else begin
          head_d[wk_q] = head_q[wk_q] + PTR_W'(1);
        end
      end

      // wait for the victim choice
      S_RNG: begin
        if (mod_done) begin
          vic = (mod_rem >= wk_q) ? mod_rem + W_BITS'(1) : mod_rem;
          tgt_d     = vic;
          tgt_out_d = 3'(vic);
          if (counts_q[wk_q] != '0) begin
            status_d = ST_THIEF_BUSY;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else if (counts_q[vic] == '0) begin
            status_d = ST_NO_STEAL;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else begin
            idx_d   = '0;
            n_d     = '0;
            state_d = S_CNT_RD;
          end
        end
      end

      // count the victim's stealable entries
      S_CNT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = phys(tgt_q, head_q[tgt_q], idx_q);
        state_d   = S_CNT_CHK;
      end

      S_CNT_CHK: begin
        nn = n_q + CNT_W'(rd_q[TAG_BITS]);
        n_d = nn;
        if (idx_q == counts_q[tgt_q] - CNT_W'(1)) begin
          if (nn == '0) begin
            status_d = ST_NO_STEAL;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else begin
            tk      = nn >> 1;
            take_d  = (tk == '0) ? CNT_W'(1) : tk;
            got_d   = '0;
            idx_d   = idx_q;
            wp_d    = idx_q;
            state_d = S_MV_RD;
          end
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_CNT_RD;
        end
      end

      // move pass from the back: taken entries go to the thief, the rest close up
      S_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = phys(tgt_q, head_q[tgt_q], idx_q);
        state_d   = S_MV_PROC;
      end

      S_MV_PROC: begin
        mem_we = 1'b1;
        if (rd_q[TAG_BITS] && (got_q < take_q)) begin
          mem_waddr = phys(wk_q, '0, take_q - CNT_W'(1) - got_q);
          mem_wdata = rd_q;
          got_d     = got_q + CNT_W'(1);
        end else begin
          mem_waddr = phys(tgt_q, head_q[tgt_q], wp_q);
          mem_wdata = rd_q;
          wp_d      = wp_q - CNT_W'(1);
        end
        if (idx_q == '0) begin
          head_d[tgt_q]   = PTR_W'(phys('0, head_q[tgt_q], take_q));
          counts_d[tgt_q] = counts_q[tgt_q] - take_q;
          head_d[wk_q]    = '0;
          counts_d[wk_q]  = take_q;
          moved_d         = 5'(take_q);
          status_d        = ST_OK;
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end else begin
          idx_d   = idx_q - CNT_W'(1);
          state_d = S_MV_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      for (int i = 0; i < WORKERS; i++) begin
        counts_q[i] <= '0;
        head_q[i]   <= '0;
        rng_q[i]    <= rng_seed(i);
      end
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      counts_q <= counts_d;
      head_q   <= head_d;
      rng_q    <= rng_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    wk_q      <= wk_d;
    tgt_q     <= tgt_d;
    best_q    <= best_d;
    ll_q      <= ll_d;
    tag_q     <= tag_d;
    st_q      <= st_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    take_q    <= take_d;
    got_q     <= got_d;
    wp_q      <= wp_d;
    status_q  <= status_d;
    tag_out_q <= tag_out_d;
    st_out_q  <= st_out_d;
    tgt_out_q <= tgt_out_d;
    moved_q   <= moved_d;
  end

  // queue memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign busy                = (state_q != S_IDLE);
  assign valid_o             = valid_q;
  assign status_o            = status_q;
  assign job_tag_out_o       = tag_out_q;
  assign job_stealable_out_o = st_out_q;
  assign target_worker_o     = tgt_out_q;
  assign moved_count_o       = moved_q;

endmodule

### rtl/wstq_modu.sv
// wstq_modu: iterative remainder of a 64-bit value by a small constant,
// MOD_STEP bits per cycle, most significant first
// depends on wstq_pkg
module wstq_modu #(
  parameter int unsigned DIVISOR = 3,
  parameter int unsigned REM_W   = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      value_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);
  import wstq_pkg::*;

  localparam int unsigned STEPS = 64 / MOD_STEP;
  localparam int unsigned STP_W = $clog2(STEPS);

  logic [63:0]      val_q, val_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [STP_W-1:0] step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  // fold the next group of bits into the remainder
  always_comb begin
    logic [REM_W:0] t;
    val_d  = val_q;
    rem_d  = rem_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    t      = '0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      t = {1'b0, rem_q};
      for (int b = 0; b < MOD_STEP; b++) begin
        t = {t[REM_W-1:0], val_q[63 - b]};
        if (t >= (REM_W+1)'(DIVISOR)) begin
          t = t - (REM_W+1)'(DIVISOR);
        end
      end
      rem_d  = t[REM_W-1:0];
      val_d  = val_q << MOD_STEP;
      step_d = step_q + STP_W'(1);
      if (step_q == STP_W'(STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
